>>> hw/rtl/pfc_pkg.sv
// Shared types, constants and square-geometry helpers for the Playfair engine.
`default_nettype none

package pfc_pkg;

  typedef logic [4:0] letter_t;
  typedef logic [4:0] cell_t;
  typedef logic [2:0] rc_t;

  localparam int SIDE     = 5;
  localparam int CELLS    = 25;
  localparam int ALPHABET = 26;

  localparam letter_t LETTER_I = 5'd8;
  localparam letter_t LETTER_J = 5'd9;
  localparam letter_t LETTER_X = 5'd23;

  localparam cell_t   CELLS_C = 5'd25;
  localparam letter_t LAST_WALK = 5'd25;

  localparam logic REQ_KEY  = 1'b0;
  localparam logic REQ_TEXT = 1'b1;

  // Controller -> datapath
  typedef struct packed {
    logic key_place;   // place the incoming key letter
    logic walk_start;  // clear alphabet walk counter
    logic walk_place;  // place walk letter, advance counter
    logic text_take;   // take a text letter into the pairing logic
    logic pos_sel_b;   // position lookup of second letter
    logic latch_pa;    // hold first letter's position
    logic latch_ofs;   // register both output cells
    logic sq_sel_o2;   // square lookup of second output cell
    logic emit_first;  // load first result beat
    logic emit_second; // load second result beat
    logic repeat_go;   // replay the same pair as the final one
  } pfc_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic key_done;
    logic pair_go;
    logic walk_done;
    logic rep_pending;
    logic out_free;
  } pfc_sts_t;

  function automatic rc_t pos_row(input cell_t p);
    rc_t r;
    if (p >= 5'd20)      r = 3'd4;
    else if (p >= 5'd15) r = 3'd3;
    else if (p >= 5'd10) r = 3'd2;
    else if (p >= 5'd5)  r = 3'd1;
    else                 r = 3'd0;
    return r;
  endfunction

  function automatic cell_t cell_of(input rc_t r, input rc_t c);
    cell_t rr;
    rr = {2'b00, r};
    return (rr << 2) + rr + {2'b00, c};
  endfunction

  function automatic rc_t pos_col(input cell_t p);
    cell_t base;
    base = cell_of(pos_row(p), 3'd0);
    return 3'(p - base);
  endfunction

  // Step one place forward (encrypt) or back (decrypt), modulo the side.
  function automatic rc_t wrap_step(input rc_t v, input logic dec);
    logic [3:0] s;
    s = {1'b0, v} + (dec ? 4'd4 : 4'd1);
    if (s >= 4'(SIDE)) s = s - 4'(SIDE);
    return s[2:0];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/pfc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pfc_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 25,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/pfc_ctrl.sv
// Sequencing state machine for key setup and pair processing.
`default_nettype none

module pfc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              req_type,
  input  wire logic              last_in,
  output logic                   in_stall,
  input  wire pfc_pkg::pfc_sts_t sts,
  output pfc_pkg::pfc_cmd_t      cmd
);
  import pfc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_RD_A,
    S_RD_B,
    S_CALC,
    S_SQ1,
    S_OUT1,
    S_OUT2
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (req_type == REQ_KEY) begin
            if (!sts.key_done) begin
              cmd.key_place = 1'b1;
              if (last_in) begin
                cmd.walk_start = 1'b1;
                state_next     = S_FILL;
              end
            end
          end else if (sts.key_done) begin
            cmd.text_take = 1'b1;
            if (sts.pair_go) state_next = S_RD_A;
          end
        end
      end
      S_FILL: begin
        cmd.walk_place = 1'b1;
        if (sts.walk_done) state_next = S_IDLE;
      end
      S_RD_A: state_next = S_RD_B;
      S_RD_B: begin
        cmd.pos_sel_b = 1'b1;
        cmd.latch_pa  = 1'b1;
        state_next    = S_CALC;
      end
      S_CALC: begin
        cmd.latch_ofs = 1'b1;
        state_next    = S_SQ1;
      end
      S_SQ1: state_next = S_OUT1;
      S_OUT1: begin
        if (sts.out_free) begin
          cmd.emit_first = 1'b1;
          cmd.sq_sel_o2  = 1'b1;
          state_next     = S_OUT2;
        end
      end
      S_OUT2: begin
        cmd.sq_sel_o2 = 1'b1;
        if (sts.out_free) begin
          cmd.emit_second = 1'b1;
          if (sts.rep_pending) begin
            // same pair again; point the square back at the first cell
            cmd.repeat_go = 1'b1;
            cmd.sq_sel_o2 = 1'b0;
            state_next    = S_OUT1;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

endmodule

`default_nettype wire

>>> hw/rtl/pfc_dp.sv
// Datapath: square build, letter pairing, cipher rules and output register.
`default_nettype none

module pfc_dp (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pfc_pkg::pfc_cmd_t cmd,
  output pfc_pkg::pfc_sts_t      sts,
  input  wire pfc_pkg::letter_t  in_letter,
  input  wire logic              in_last,
  input  wire logic              cfg_wr_en,
  input  wire logic              cfg_wr_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output pfc_pkg::letter_t       out_letter,
  output logic                   last_out
);
  import pfc_pkg::*;

  // control state
  cell_t                  fill_count;
  logic [ALPHABET-1:0]    used;
  letter_t                walk_cnt;
  logic                   held_valid;
  logic                   rep_pending;
  logic                   decrypt_mode;
  // payload
  letter_t                held_letter;
  letter_t                pair_a;
  letter_t                pair_b;
  logic                   pair_last;
  cell_t                  pa;
  cell_t                  o1;
  cell_t                  o2;

  // ---------------- key placement ----------------
  letter_t place_src;
  letter_t place_l;
  logic    place_ok;

  always_comb begin
    place_src = cmd.walk_place ? walk_cnt : in_letter;
    place_l   = (place_src == LETTER_J) ? LETTER_I : place_src;
    place_ok  = (cmd.key_place || cmd.walk_place) && (place_l < 5'(ALPHABET)) &&
                !used[place_l] && (fill_count < CELLS_C);
  end

  // ---------------- text pairing ----------------
  letter_t tl;
  logic    tl_ok;
  logic    doubled;
  logic    go;
  letter_t na;
  letter_t nb;
  logic    nlast;
  logic    nrep;
  logic    nheld_valid;
  letter_t nheld;

  always_comb begin
    tl          = (in_letter == LETTER_J) ? LETTER_I : in_letter;
    tl_ok       = (tl < 5'(ALPHABET));
    doubled     = tl_ok && held_valid && (tl == held_letter);
    go          = 1'b0;
    na          = held_letter;
    nb          = LETTER_X;
    nlast       = 1'b1;
    nrep        = 1'b0;
    nheld_valid = held_valid;
    nheld       = held_letter;
    if (tl_ok && held_valid) begin
      go          = 1'b1;
      nb          = doubled ? LETTER_X : tl;
      nlast       = doubled ? 1'b0 : in_last;
      nrep        = doubled && in_last;
      nheld_valid = doubled && !in_last;
    end else if (tl_ok) begin
      na          = tl;
      nheld       = tl;
      go          = in_last;
      nheld_valid = !in_last;
    end else if (in_last && held_valid) begin
      go          = 1'b1;
      nheld_valid = 1'b0;
    end
  end

  // ---------------- memories ----------------
  cell_t   pos_rdata;
  letter_t sq_rdata;

  pfc_ram #(.WIDTH(5), .DEPTH(ALPHABET)) u_pos_ram (
    .clk   (clk),
    .we    (place_ok),
    .waddr (place_l),
    .wdata (fill_count),
    .raddr (cmd.pos_sel_b ? pair_b : pair_a),
    .rdata (pos_rdata)
  );

  pfc_ram #(.WIDTH(5), .DEPTH(CELLS)) u_sq_ram (
    .clk   (clk),
    .we    (place_ok),
    .waddr (fill_count),
    .wdata (place_l),
    .raddr (cmd.sq_sel_o2 ? o2 : o1),
    .rdata (sq_rdata)
  );

  // ---------------- cipher rules ----------------
  rc_t   r1, c1, r2, c2;
  cell_t o1_next;
  cell_t o2_next;

  always_comb begin
    r1 = pos_row(pa);
    c1 = pos_col(pa);
    r2 = pos_row(pos_rdata);
    c2 = pos_col(pos_rdata);
    if (r1 == r2) begin
      o1_next = cell_of(r1, wrap_step(c1, decrypt_mode));
      o2_next = cell_of(r2, wrap_step(c2, decrypt_mode));
    end else if (c1 == c2) begin
      o1_next = cell_of(wrap_step(r1, decrypt_mode), c1);
      o2_next = cell_of(wrap_step(r2, decrypt_mode), c2);
    end else begin
      o1_next = cell_of(r1, c2);
      o2_next = cell_of(r2, c1);
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count   <= '0;
      used         <= '0;
      walk_cnt     <= '0;
      held_valid   <= 1'b0;
      held_letter  <= '0;
      rep_pending  <= 1'b0;
      decrypt_mode <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) decrypt_mode <= cfg_wr_data;

      if (place_ok) begin
        fill_count    <= fill_count + 5'd1;
        used[place_l] <= 1'b1;
        if (place_l == LETTER_I) used[LETTER_J] <= 1'b1;
      end
      if (cmd.walk_start) begin
        walk_cnt <= '0;
      end else if (cmd.walk_place) begin
        walk_cnt <= walk_cnt + 5'd1;
      end

      if (cmd.text_take) begin
        held_valid  <= nheld_valid;
        held_letter <= nheld;
        rep_pending <= nrep;
      end else if (cmd.repeat_go) begin
        rep_pending <= 1'b0;
      end

      if (cmd.emit_first || cmd.emit_second) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.text_take) begin
      pair_a    <= na;
      pair_b    <= nb;
      pair_last <= nlast;
    end else if (cmd.repeat_go) begin
      pair_last <= 1'b1;
    end
    if (cmd.latch_pa)  pa <= pos_rdata;
    if (cmd.latch_ofs) begin
      o1 <= o1_next;
      o2 <= o2_next;
    end
    if (cmd.emit_first) begin
      out_letter <= sq_rdata;
      last_out   <= 1'b0;
    end else if (cmd.emit_second) begin
      out_letter <= sq_rdata;
      last_out   <= pair_last;
    end
  end

  always_comb begin
    sts.key_done    = (fill_count == CELLS_C);
    sts.pair_go     = go;
    sts.walk_done   = (walk_cnt == LAST_WALK);
    sts.rep_pending = rep_pending;
    sts.out_free    = !out_valid || !out_stall;
  end

endmodule

`default_nettype wire

>>> hw/rtl/playfair_cipher_engine_top.sv
// Playfair engine: a key letter is taken while idle; the final key letter adds an alphabet walk.
// A text letter that closes a pair occupies the engine through two position-RAM reads, cell
// math and two square-RAM reads; a doubled final letter adds a replay of the pair's results.
// A letter that only opens a pair keeps the engine idle. OUT1 loads the first result beat.
// Synchronous active-high reset clears the letter-used flags, fill count, held letter, mode and
// output valid at once; square and position RAMs are not cleared and need no clearing pass.
`default_nettype none

module playfair_cipher_engine_top (
  input  wire logic             clk,
  input  wire logic             rst,
  // input beats
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             req_type,
  input  wire pfc_pkg::letter_t letter,
  input  wire logic             last_in,
  // result beats
  output logic                  out_valid,
  input  wire logic             out_stall,
  output pfc_pkg::letter_t      out_letter,
  output logic                  last_out,
  // decrypt_mode register
  input  wire logic             cfg_wr_en,
  input  wire logic             cfg_wr_data
);
  import pfc_pkg::*;

  pfc_cmd_t cmd;
  pfc_sts_t sts;

  // Sequencer: accepts input beats only when idle, walks the alphabet after the last
  // key letter, and steps each pair through lookup, cell math and two result beats.
  pfc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_type (req_type),
    .last_in  (last_in),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: square and position RAMs, pairing with filler x, row / column /
  // rectangle rules, and the output register that decouples the result side.
  pfc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_letter   (letter),
    .in_last     (last_in),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_letter  (out_letter),
    .last_out    (last_out)
  );

endmodule

`default_nettype wire

>>> tb/playfair_cipher_engine_top_test.sv
// Self-checking testbench for the Playfair cipher engine: scoreboard class plus beat drivers.
`default_nettype none

import pfc_pkg::*;

typedef struct packed {
  letter_t letter;
  logic    fin;
} letter_beat_t;

// Square builder and pair cipher predictor; holds the expected result beats in order.
class playfair_scoreboard;
  letter_t      square [CELLS];
  int           letter_position [ALPHABET];
  bit           letter_used [ALPHABET];
  int           fill;
  letter_t      held;
  bit           held_ok;
  bit           decrypt;
  letter_beat_t want_q [$];
  int           errors;
  int           n_in;
  int           n_out;

  function new();
    foreach (square[k]) square[k] = '0;
    foreach (letter_used[k]) begin
      letter_used[k] = 0;
      letter_position[k] = 0;
    end
    fill = 0;
    held = '0;
    held_ok = 0;
    decrypt = 0;
    errors = 0;
    n_in = 0;
    n_out = 0;
  endfunction

  // Put a letter in the next free cell unless it is used, out of range or the square is full.
  function void place(letter_t l);
    letter_t v;
    v = (l == LETTER_J) ? LETTER_I : l;
    if (v >= ALPHABET || letter_used[v] || fill >= CELLS) return;
    square[fill] = v;
    letter_position[v] = fill;
    letter_used[v] = 1;
    if (v == LETTER_I) begin
      letter_used[LETTER_J] = 1;
      letter_position[LETTER_J] = fill;
    end
    fill++;
  endfunction

  // Append one predicted result beat at the tail of the queue.
  function void queue_beat(letter_t v, bit fin);
    letter_beat_t b;
    b.letter = v;
    b.fin    = fin;
    want_q.insert(want_q.size(), b);
  endfunction

  function void encode_pair(letter_t a, letter_t b, bit fin);
    int pa, pb, r1, c1, r2, c2, step, o1, o2;
    pa = letter_position[a];
    pb = letter_position[b];
    r1 = pa / SIDE;
    c1 = pa % SIDE;
    r2 = pb / SIDE;
    c2 = pb % SIDE;
    step = decrypt ? 4 : 1;
    if (r1 == r2) begin
      o1 = r1 * SIDE + (c1 + step) % SIDE;
      o2 = r2 * SIDE + (c2 + step) % SIDE;
    end else if (c1 == c2) begin
      o1 = ((r1 + step) % SIDE) * SIDE + c1;
      o2 = ((r2 + step) % SIDE) * SIDE + c2;
    end else begin
      o1 = r1 * SIDE + c2;
      o2 = r2 * SIDE + c1;
    end
    queue_beat(square[o1], 1'b0);
    queue_beat(square[o2], fin);
  endfunction

  function void note_input(logic kind, letter_t l, bit fin);
    letter_t v;
    n_in++;
    if (kind == REQ_KEY) begin
      if (fill >= CELLS) return;
      place(l);
      if (fin)
        for (int a = 0; a < ALPHABET; a++) place(letter_t'(a));
      return;
    end
    if (fill < CELLS) return;
    v = (l == LETTER_J) ? LETTER_I : l;
    if (v < ALPHABET) begin
      if (held_ok) begin
        if (v == held) encode_pair(held, LETTER_X, 1'b0);
        else begin
          encode_pair(held, v, fin);
          held_ok = 0;
        end
      end else begin
        held = v;
        held_ok = 1;
      end
    end
    if (fin && held_ok) begin
      encode_pair(held, LETTER_X, 1'b1);
      held_ok = 0;
    end
  endfunction

  function void check_result(letter_t got, logic got_last);
    letter_beat_t w;
    n_out++;
    if (want_q.size() == 0) begin
      $display("%0t: unexpected result beat, got out_letter %0d last_out %0b",
               $time, got, got_last);
      errors++;
      return;
    end
    w = want_q.pop_front();
    if (got !== w.letter) begin
      $display("%0t: out_letter mismatch, expected %0d got %0d", $time, w.letter, got);
      errors++;
    end
    if (got_last !== w.fin) begin
      $display("%0t: last_out mismatch, expected %0b got %0b", $time, w.fin, got_last);
      errors++;
    end
  endfunction
endclass

module playfair_cipher_engine_top_test;

  // Worst case per beat: the engine's pair path, four results each waiting out long stalls,
  // plus sender gaps; several times over for ~310 beats and the phase pauses.
  localparam int LIMIT  = 300000;
  // Quiet cycles before a register write and at the end: covers the alphabet walk and the
  // pair path with margin.
  localparam int SETTLE = 48;

  logic    clk;
  logic    rst;
  logic    in_valid;
  logic    in_stall;
  logic    req_type;
  letter_t letter;
  logic    last_in;
  logic    out_valid;
  logic    out_stall;
  letter_t out_letter;
  logic    last_out;
  logic    cfg_wr_en;
  logic    cfg_wr_data;

  playfair_scoreboard sb;

  int      gap_pct;    // chance per draw before a beat that the sender idles; drawn until it sends
  int      stall_pct;  // chance per cycle that the receiver stalls
  int      cycles;
  int      r;
  int      klen;
  int      pick;
  bit      early_full;
  letter_t l;
  letter_t prev;
  letter_t perm [ALPHABET];
  letter_t tmp;

  playfair_cipher_engine_top u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .letter      (letter),
    .last_in     (last_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_letter  (out_letter),
    .last_out    (last_out),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver back-pressure, known from time zero and redrawn every falling edge.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Result beats are taken at the rising edge and checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_letter, last_out);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: timeout after %0d cycles, %0d results still due",
             $time, cycles, sb.want_q.size());
    $display("Test completed with failures");
    $finish;
  end

  // Present one input beat and hold it until accepted. Entered and left at a falling edge;
  // valid stays high on return so back-to-back beats never drop it.
  task automatic send_beat(logic kind, letter_t v, bit fin);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    req_type = kind;
    letter   = v;
    last_in  = fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(kind, v, fin);
    @(negedge clk);
  endtask

  // Drain all predicted results, then let the engine go quiet. Ends at a falling edge.
  task automatic settle();
    in_valid = 1'b0;
    while (sb.want_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  // decrypt_mode write; the predictor switches at the same edge as the engine.
  task automatic write_mode(bit m);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = m;
    @(posedge clk);
    sb.decrypt = m;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  initial begin
    // Every input known from time zero.
    rst         = 1'b1;
    in_valid    = 1'b0;
    req_type    = REQ_KEY;
    letter      = '0;
    last_in     = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    gap_pct     = 0;
    stall_pct   = 0;
    prev        = '0;
    sb = new();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_mode(1'b0);

    // Text before the key is finished is dropped by the engine.
    send_beat(REQ_TEXT, 5'd0, 1'b0);
    send_beat(REQ_TEXT, 5'd25, 1'b1);

    // Key from a shuffled alphabet. One run in three sends all 26 letters unmarked, so the
    // square fills on its own (i and j collide); otherwise a short key closed by a marked
    // letter that triggers the alphabet walk. A repeat and an out-of-range code are mixed in.
    foreach (perm[k]) perm[k] = letter_t'(k);
    for (int k = ALPHABET - 1; k > 0; k--) begin
      pick = $urandom_range(0, k);
      tmp = perm[k];
      perm[k] = perm[pick];
      perm[pick] = tmp;
    end
    early_full = ($urandom_range(0, 2) == 0);
    klen = early_full ? ALPHABET : $urandom_range(3, 18);
    for (int k = 0; k < klen; k++) begin
      send_beat(REQ_KEY, perm[k], 1'b0);
      if (k == 1) send_beat(REQ_KEY, perm[0], 1'b0);
      if (k == 2) send_beat(REQ_KEY, letter_t'($urandom_range(26, 31)), 1'b0);
    end
    // Closing letter may itself be out of range; its mark still ends the key.
    if (!early_full) send_beat(REQ_KEY, letter_t'($urandom_range(0, 31)), 1'b1);
    // Key beats once the square is full are ignored.
    send_beat(REQ_KEY, letter_t'($urandom_range(0, 31)), 1'b1);

    // Directed text, picked from the predicted square so each rule is hit whatever the key.
    send_beat(REQ_TEXT, sb.square[0], 1'b0);   // same row
    send_beat(REQ_TEXT, sb.square[1], 1'b0);
    send_beat(REQ_TEXT, sb.square[0], 1'b0);   // same column
    send_beat(REQ_TEXT, sb.square[5], 1'b0);
    send_beat(REQ_TEXT, sb.square[6], 1'b0);   // rectangle
    send_beat(REQ_TEXT, sb.square[0], 1'b0);
    send_beat(REQ_TEXT, sb.square[7], 1'b0);   // doubled letter, filler goes in
    send_beat(REQ_TEXT, sb.square[7], 1'b0);
    send_beat(REQ_TEXT, sb.square[13], 1'b0);
    send_beat(REQ_TEXT, LETTER_J, 1'b0);       // j read as i
    send_beat(REQ_TEXT, 5'd25, 1'b0);
    send_beat(REQ_TEXT, 5'd0, 1'b1);           // odd final letter
    send_beat(REQ_TEXT, LETTER_X, 1'b1);       // x paired with filler x
    send_beat(REQ_TEXT, sb.square[3], 1'b0);   // doubled final letter: four results
    send_beat(REQ_TEXT, sb.square[3], 1'b1);
    send_beat(REQ_TEXT, 5'd30, 1'b1);          // bad code, nothing held: no result
    send_beat(REQ_TEXT, sb.square[2], 1'b0);   // bad code with mark flushes held letter
    send_beat(REQ_TEXT, 5'd31, 1'b1);
    send_beat(REQ_TEXT, 5'd27, 1'b0);          // bad code skipped before a pair
    send_beat(REQ_TEXT, sb.square[4], 1'b0);
    send_beat(REQ_TEXT, sb.square[9], 1'b0);

    // Random phases: idle pattern cycles through none / sender / receiver / both;
    // mode alternates, so none and receiver run decrypting, sender and both encrypting.
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      case (ph % 4)
        0: begin
          gap_pct = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct = 73;
          stall_pct = 0;
        end
        2: begin
          gap_pct = 0;
          stall_pct = 73;
        end
        default: begin
          gap_pct = 36;
          stall_pct = 36;
        end
      endcase
      write_mode(ph % 2 == 0);
      for (int n = 0; n < 33; n++) begin
        r = $urandom_range(0, 99);
        if (r < 5) l = letter_t'($urandom_range(26, 31));
        else if (r < 12) l = LETTER_J;
        else if (r < 26) l = prev;           // doubled letters
        else l = letter_t'($urandom_range(0, 25));
        // Rare stray key beats are noise; the engine must ignore them.
        send_beat(($urandom_range(0, 49) == 0) ? REQ_KEY : REQ_TEXT, l,
                  $urandom_range(0, 7) == 0);
        prev = l;
      end
    end

    settle();
    $display("Run: %0d input beats, %0d result beats; key of %0d letters (%s).",
             sb.n_in, sb.n_out, klen, early_full ? "square filled early" : "alphabet walk");
    $display("Both cipher directions under no, sender, receiver and mixed idling.");
    if (sb.errors == 0 && sb.want_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
hw/rtl/pfc_pkg.sv
hw/rtl/pfc_ram.sv
hw/rtl/pfc_ctrl.sv
hw/rtl/pfc_dp.sv
hw/rtl/playfair_cipher_engine_top.sv
tb/playfair_cipher_engine_top_test.sv
